/* hw/rtl/amg_pkg.sv */
package amg_pkg;

  // Matrix geometry
  localparam int MAX_V   = 16;
  localparam int V_W     = $clog2(MAX_V);
  localparam int ADDR_W  = $clog2(MAX_V * MAX_V);
  localparam int DEPTH   = MAX_V * MAX_V;

  // Field widths
  localparam int IDX_W   = 4;
  localparam int FUNC_W  = 3;
  localparam int WGT_W   = 16;
  localparam int CNT_W   = 9;
  localparam int VC_W    = 5;
  localparam int DEG_W   = V_W + 1;
  localparam int CMP_W   = WGT_W + 1;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic [VC_W-1:0] VC_RESET = VC_W'(16);

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_SET_EDGE   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEL_EDGE   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ_EDGE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MAX_DEGREE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_HEAVIEST   = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [IDX_W-1:0]        src_vertex;
    logic [IDX_W-1:0]        dst_vertex;
    logic signed [WGT_W-1:0] edge_weight;
  } req_t;

  // Control from the sequencer to the compare unit
  typedef struct packed {
    logic           clr;
    logic           en;
    logic           deg_mode;
    logic           row_end;
    logic [V_W-1:0] row;
    logic [V_W-1:0] col;
  } scan_ctl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] vertex;
  } scan_res_t;

  function automatic logic [ADDR_W-1:0] mat_addr(input logic [V_W-1:0] row,
                                                 input logic [V_W-1:0] col);
    mat_addr = ADDR_W'(row) * ADDR_W'(MAX_V) + ADDR_W'(col);
  endfunction

endpackage

/* hw/rtl/amg_req_if.sv */
interface amg_req_if;
  logic                               valid;
  logic                               ready;
  logic [amg_pkg::FUNC_W-1:0]         func;
  logic [amg_pkg::IDX_W-1:0]          src_vertex;
  logic [amg_pkg::IDX_W-1:0]          dst_vertex;
  logic signed [amg_pkg::WGT_W-1:0]   edge_weight;

  modport source (output valid, func, src_vertex, dst_vertex, edge_weight, input ready);
  modport sink   (input valid, func, src_vertex, dst_vertex, edge_weight, output ready);
endinterface

/* hw/rtl/amg_rsp_if.sv */
interface amg_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [amg_pkg::IDX_W-1:0]          result_vertex;
  logic signed [amg_pkg::WGT_W-1:0]   read_weight;
  logic                               edge_present;
  logic                               found;
  logic [amg_pkg::CNT_W-1:0]          edge_total;
  logic                               range_error;

  modport source (output valid, result_vertex, read_weight, edge_present, found,
                  edge_total, range_error, input ready);
  modport sink   (input valid, result_vertex, read_weight, edge_present, found,
                  edge_total, range_error, output ready);
endinterface

/* hw/rtl/amg_apb_regs.sv */
module amg_apb_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [amg_pkg::PADDR_W-1:0]  paddr,
  input  logic [amg_pkg::PDATA_W-1:0]  pwdata,
  output logic [amg_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [amg_pkg::VC_W-1:0]     vertex_count
);

  logic                       reg_idx;
  logic                       wr_en;
  logic [amg_pkg::VC_W-1:0]   vc_r;
  logic [amg_pkg::VC_W-1:0]   vc_nxt;

  // byte offset bits are ignored; one register per word
  assign reg_idx = paddr[amg_pkg::PADDR_W-1];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    vc_nxt = vc_r;
    if (wr_en && reg_idx == amg_pkg::REG_VERTEX_COUNT) begin
      vc_nxt = pwdata[amg_pkg::VC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= amg_pkg::VC_RESET;
    end else begin
      vc_r <= vc_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      amg_pkg::REG_VERTEX_COUNT: prdata = amg_pkg::PDATA_W'(vc_r);
      default:                   prdata = '0;
    endcase
  end

  assign vertex_count = vc_r;

endmodule

/* hw/rtl/amg_scan_unit.sv */
module amg_scan_unit (
  input  logic                             clk,
  input  amg_pkg::scan_ctl_t               ctl,
  input  logic signed [amg_pkg::WGT_W-1:0] data,
  output amg_pkg::scan_res_t               res
);

  logic [amg_pkg::DEG_W-1:0]        deg_r;
  logic [amg_pkg::DEG_W-1:0]        deg_nxt;
  logic [amg_pkg::DEG_W-1:0]        deg_sum;
  logic signed [amg_pkg::CMP_W-1:0] best_r;
  logic signed [amg_pkg::CMP_W-1:0] best_nxt;
  logic signed [amg_pkg::CMP_W-1:0] cand;
  logic [amg_pkg::IDX_W-1:0]        idx_r;
  logic [amg_pkg::IDX_W-1:0]        idx_nxt;
  logic                             found_r;
  logic                             found_nxt;
  logic                             upd;
  logic                             take;

  assign deg_sum = deg_r + amg_pkg::DEG_W'(data != '0);

  // one signed compare serves both searches
  always_comb begin
    if (ctl.deg_mode) begin
      cand = $signed({{(amg_pkg::CMP_W-amg_pkg::DEG_W){1'b0}}, deg_sum});
    end else begin
      cand = $signed({data[amg_pkg::WGT_W-1], data});
    end
  end

  assign upd  = ctl.en && (!ctl.deg_mode || ctl.row_end);
  assign take = upd && (cand > best_r);

  always_comb begin
    deg_nxt   = deg_r;
    best_nxt  = best_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    if (ctl.clr) begin
      deg_nxt   = '0;
      best_nxt  = '0;
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end else if (ctl.en) begin
      deg_nxt = ctl.row_end ? '0 : deg_sum;
      if (take) begin
        best_nxt  = cand;
        found_nxt = 1'b1;
        idx_nxt   = ctl.deg_mode ? amg_pkg::IDX_W'(ctl.row) : amg_pkg::IDX_W'(ctl.col);
      end
    end
  end

  always_ff @(posedge clk) begin
    deg_r   <= deg_nxt;
    best_r  <= best_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
  end

  assign res.found  = found_r;
  assign res.vertex = idx_r;

endmodule

/* hw/rtl/adjacency_matrix_graph_engine_unit.sv */
// Weighted directed graph held as a 16x16 adjacency matrix with an edge count.
// Requests arrive on in_req (valid/ready); each gives exactly one response on
// out_rsp. Funcs: set edge, delete edge, read weight, max-degree vertex,
// heaviest positive neighbor of src_vertex. Out-of-range indices flag
// range_error and change nothing.
// vertex_count is written through the APB port (word 0); the user must write it
// only while idle, as the block itself does not enforce it. From request accept to response:
//   set/delete/read: memory read, update, response load
//   heaviest neighbor: scan of the src_vertex row; max degree: n x n scan, n = vertex count
//   range error, unknown func or max degree with no vertices: response load only
// The matrix lives in one single-port-read memory; scans read one entry per
// cycle, which sets the search time. One request is worked at a time.
// After reset a clearing pass writes zero to all 256 entries while in_req.ready
// is low; APB writes are taken throughout.
// The response sits in an output register; a new request is accepted while
// it waits, and a finished result holds until out_rsp.ready frees the register.
module adjacency_matrix_graph_engine_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  amg_req_if.sink                      in_req,
  amg_rsp_if.source                    out_rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [amg_pkg::PADDR_W-1:0]  paddr,
  input  logic [amg_pkg::PDATA_W-1:0]  pwdata,
  output logic [amg_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_ACCESS = 7'b0000100,
    S_UPDATE = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [amg_pkg::VC_W-1:0]           vertex_count;
  logic [amg_pkg::VC_W-1:0]           n_now;
  logic [amg_pkg::VC_W-1:0]           n_r, n_nxt;
  logic [amg_pkg::VC_W-1:0]           last;
  amg_pkg::req_t                      req_in;
  amg_pkg::req_t                      req_r, req_nxt;
  logic                               rerr_r, rerr_nxt;
  logic                               rerr_in;
  logic                               accept;

  logic signed [amg_pkg::WGT_W-1:0]   mem [amg_pkg::DEPTH];
  logic signed [amg_pkg::WGT_W-1:0]   mem_rdata_r;
  logic                               mem_we, mem_re;
  logic [amg_pkg::ADDR_W-1:0]         mem_waddr, mem_raddr;
  logic signed [amg_pkg::WGT_W-1:0]   mem_wdata;

  logic [amg_pkg::ADDR_W-1:0]         clr_addr_r, clr_addr_nxt;
  logic [amg_pkg::V_W-1:0]            i_r, i_nxt, j_r, j_nxt;
  logic                               j_last, i_last;

  logic                               tag_vld_r, tag_end_r;
  logic [amg_pkg::V_W-1:0]            tag_row_r, tag_col_r;
  amg_pkg::scan_ctl_t                 scan_ctl;
  amg_pkg::scan_res_t                 scan_res;

  logic [amg_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [amg_pkg::WGT_W-1:0]   rd_r, rd_nxt;
  logic                               present_r, present_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_load;
  logic [amg_pkg::IDX_W-1:0]          o_vertex_r;
  logic signed [amg_pkg::WGT_W-1:0]   o_weight_r;
  logic                               o_present_r, o_found_r, o_rerr_r;
  logic [amg_pkg::CNT_W-1:0]          o_total_r;

  amg_apb_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .vertex_count (vertex_count)
  );

  assign n_now = (vertex_count > amg_pkg::VC_W'(amg_pkg::MAX_V)) ?
                 amg_pkg::VC_W'(amg_pkg::MAX_V) : vertex_count;

  assign req_in.func        = in_req.func;
  assign req_in.src_vertex  = in_req.src_vertex;
  assign req_in.dst_vertex  = in_req.dst_vertex;
  assign req_in.edge_weight = in_req.edge_weight;

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;

  always_comb begin
    case (req_in.func)
      amg_pkg::FUNC_SET_EDGE, amg_pkg::FUNC_DEL_EDGE, amg_pkg::FUNC_READ_EDGE:
        rerr_in = (amg_pkg::VC_W'(req_in.src_vertex) >= n_now) ||
                  (amg_pkg::VC_W'(req_in.dst_vertex) >= n_now);
      amg_pkg::FUNC_HEAVIEST:
        rerr_in = (amg_pkg::VC_W'(req_in.src_vertex) >= n_now);
      default:
        rerr_in = 1'b0;
    endcase
  end

  assign last   = n_r - amg_pkg::VC_W'(1);
  assign j_last = (amg_pkg::VC_W'(j_r) == last);
  assign i_last = (amg_pkg::VC_W'(i_r) == last);
  assign out_load = !out_valid_r || out_rsp.ready;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    req_nxt      = req_r;
    rerr_nxt     = rerr_r;
    n_nxt        = n_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    cnt_nxt      = cnt_r;
    rd_nxt       = rd_r;
    present_nxt  = present_r;
    mem_we       = 1'b0;
    mem_waddr    = amg_pkg::mat_addr(amg_pkg::V_W'(req_r.src_vertex),
                                     amg_pkg::V_W'(req_r.dst_vertex));
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = mem_waddr;

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + amg_pkg::ADDR_W'(1);
        if (&clr_addr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_nxt     = req_in;
          rerr_nxt    = rerr_in;
          n_nxt       = n_now;
          rd_nxt      = '0;
          present_nxt = 1'b0;
          i_nxt       = '0;
          j_nxt       = '0;
          state_nxt   = S_RESP;
          if (!rerr_in) begin
            case (req_in.func)
              amg_pkg::FUNC_SET_EDGE, amg_pkg::FUNC_DEL_EDGE, amg_pkg::FUNC_READ_EDGE:
                state_nxt = S_ACCESS;
              amg_pkg::FUNC_MAX_DEGREE:
                if (n_now != '0) begin
                  state_nxt = S_SCAN;
                end
              amg_pkg::FUNC_HEAVIEST: begin
                i_nxt     = amg_pkg::V_W'(req_in.src_vertex);
                state_nxt = S_SCAN;
              end
              default: state_nxt = S_RESP;
            endcase
          end
        end
      end
      S_ACCESS: begin
        mem_re    = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        case (req_r.func)
          amg_pkg::FUNC_SET_EDGE: begin
            mem_we    = 1'b1;
            mem_wdata = req_r.edge_weight;
            if (mem_rdata_r == '0 && req_r.edge_weight != '0) begin
              cnt_nxt = cnt_r + amg_pkg::CNT_W'(1);
            end else if (mem_rdata_r != '0 && req_r.edge_weight == '0) begin
              cnt_nxt = cnt_r - amg_pkg::CNT_W'(1);
            end
          end
          amg_pkg::FUNC_DEL_EDGE: begin
            mem_we = 1'b1;
            if (mem_rdata_r != '0) begin
              cnt_nxt = cnt_r - amg_pkg::CNT_W'(1);
            end
          end
          default: begin
            rd_nxt      = mem_rdata_r;
            present_nxt = (mem_rdata_r != '0);
          end
        endcase
        state_nxt = S_RESP;
      end
      S_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = amg_pkg::mat_addr(i_r, j_r);
        j_nxt     = j_r + amg_pkg::V_W'(1);
        if (j_last) begin
          j_nxt = '0;
          if (req_r.func == amg_pkg::FUNC_MAX_DEGREE && !i_last) begin
            i_nxt = i_r + amg_pkg::V_W'(1);
          end else begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      cnt_r      <= '0;
      tag_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      cnt_r      <= cnt_nxt;
      tag_vld_r  <= (state_r == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    rerr_r    <= rerr_nxt;
    n_r       <= n_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    rd_r      <= rd_nxt;
    present_r <= present_nxt;
    tag_row_r <= i_r;
    tag_col_r <= j_r;
    tag_end_r <= j_last;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // read data arrives in the cycle after the address; the tags follow it
  assign scan_ctl.clr      = accept;
  assign scan_ctl.en       = tag_vld_r;
  assign scan_ctl.deg_mode = (req_r.func == amg_pkg::FUNC_MAX_DEGREE);
  assign scan_ctl.row_end  = tag_end_r;
  assign scan_ctl.row      = tag_row_r;
  assign scan_ctl.col      = tag_col_r;

  amg_scan_unit u_scan (
    .clk  (clk),
    .ctl  (scan_ctl),
    .data (mem_rdata_r),
    .res  (scan_res)
  );

  // response register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_RESP && out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESP && out_load) begin
      o_vertex_r  <= scan_res.vertex;
      o_weight_r  <= rd_r;
      o_present_r <= present_r;
      o_found_r   <= scan_res.found;
      o_total_r   <= cnt_r;
      o_rerr_r    <= rerr_r;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.result_vertex = o_vertex_r;
  assign out_rsp.read_weight   = o_weight_r;
  assign out_rsp.edge_present  = o_present_r;
  assign out_rsp.found         = o_found_r;
  assign out_rsp.edge_total    = o_total_r;
  assign out_rsp.range_error   = o_rerr_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= amg_pkg::CNT_W'(amg_pkg::DEPTH))
    else $error("edge count above matrix size");

  a_resp_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("response loaded outside response state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> (amg_pkg::VC_W'(i_r) < n_r) && (amg_pkg::VC_W'(j_r) < n_r))
    else $error("scan address outside active vertices");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_req.ready && !mem_re)
    else $error("request path active during clearing pass");
`endif

endmodule
